/* rtl/qapm_pkg.sv */
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared types and constants for the quadrotor PD attitude mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

	localparam int DATA_WIDTH_DEF = 16;

	localparam logic [15:0] THRUST_OFFSET = 16'd717;
	localparam logic [20:0] NOMINAL_BASE  = 21'd3300;
	localparam logic [25:0] NOMINAL_SCALE = 26'd40000000;
	localparam logic [12:0] MIN_BATTERY   = 13'd1000;
	localparam logic [15:0] AGE_MAX       = 16'hFFFF;
	localparam logic [15:0] MOTOR_MAX     = 16'hFFFF;

	typedef enum logic [2:0] {
		REG_ROLL_ANGLE  = 3'd0,
		REG_PITCH_ANGLE = 3'd1,
		REG_YAW_ANGLE   = 3'd2,
		REG_ROLL_RATE   = 3'd3,
		REG_PITCH_RATE  = 3'd4,
		REG_YAW_RATE    = 3'd5,
		REG_TIMEOUT     = 3'd6
	} reg_idx_t;

	typedef enum logic {
		OP_SETPOINT = 1'b0,
		OP_TICK     = 1'b1
	} opcode_t;

	typedef enum logic {
		MODE_SQRT = 1'b0,
		MODE_DIV  = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} unit_ctrl_t;

	typedef enum logic [1:0] {
		KIND_ROLL  = 2'd0,
		KIND_PITCH = 2'd1,
		KIND_YAW   = 2'd2
	} term_kind_t;

	typedef struct packed {
		logic       mul_en;
		logic       acc_term;
		logic       acc_init;
		term_kind_t kind;
		logic       rate;
	} mac_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ_GO,
		S_SQ_WAIT,
		S_NOM_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_ACC_INIT,
		S_TERMS,
		S_DRAIN,
		S_OUT
	} state_t;

endpackage

/* rtl/quad_attitude_pd_mixer_unit.sv */
// ----------------------------------------------------------------------------
// quad_attitude_pd_mixer_unit
// Plus-frame PD attitude controller and motor mixer for a quadrotor.
// ----------------------------------------------------------------------------
// Usage: setpoint items (opcode 0) on the input channel store the desired
// angles, rates and thrust and return nothing. Tick items (opcode 1) carry
// the measurements and return one result with four motor values and the
// stale flag. Gains and the timeout are written through wr_en, wr_index and
// wr_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. A setpoint leaves the block idle. A
// tick runs the square root and then the division in the shared
// shift-subtract unit, then the multiplier and sequencer steps, before
// out_valid rises. The input is stalled for the whole tick, so the next
// item is taken only after the result has moved into the output register.
// Reset loads the default gains and timeout and clears the setpoint and age.
// A result waits in the output register while out_stall is high; a new
// tick may be accepted meanwhile but its result waits until that transfer.
// ----------------------------------------------------------------------------
module quad_attitude_pd_mixer_unit import qapm_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic signed [DATA_WIDTH-1:0] roll,
	input  logic signed [DATA_WIDTH-1:0] pitch,
	input  logic signed [DATA_WIDTH-1:0] yaw,
	input  logic signed [DATA_WIDTH-1:0] rate_x,
	input  logic signed [DATA_WIDTH-1:0] rate_y,
	input  logic signed [DATA_WIDTH-1:0] rate_z,
	input  logic [15:0]                  thrust_cmd,
	input  logic [12:0]                  battery_mv,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [15:0]                  motor_front,
	output logic [15:0]                  motor_right,
	output logic [15:0]                  motor_back,
	output logic [15:0]                  motor_left,
	output logic                         setpoint_stale,
	input  logic                         wr_en,
	input  logic [2:0]                   wr_index,
	input  logic [15:0]                  wr_data
);

	localparam int MB = (DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17;
	localparam int PW = 27 + MB;
	localparam int ACC_W = PW + 6;

	state_t state_q, state_n;
	logic [15:0] gain_q [6];
	logic [15:0] timeout_q, age_q, age_n, want_thrust_q, dthr;
	logic signed [DATA_WIDTH-1:0] want_q [6], meas_q [6], in_vec [6];
	logic [12:0] mv_q;
	logic        stale_q, stale_n, accept;
	logic [2:0]  idx_q;
	logic signed [DATA_WIDTH:0] err;
	logic [20:0] nominal;

	unit_ctrl_t  uctrl;
	logic [31:0] unum, ures;
	logic        udone;
	mac_cmd_t    mcmd;
	logic [25:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [ACC_W-1:0] init_val, acc [4];
	logic signed [PW-1:0] prod;
	logic [15:0] motor [4];
	logic        out_valid_q, load_out;
	logic [15:0] motor_q [4];
	logic        out_stale_q;

	assign in_vec = '{roll, pitch, yaw, rate_x, rate_y, rate_z};
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign age_n   = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
	assign stale_n = (age_n > timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[REG_ROLL_ANGLE]  <= 16'd3208;
			gain_q[REG_PITCH_ANGLE] <= 16'd3208;
			gain_q[REG_YAW_ANGLE]   <= 16'd3208;
			gain_q[REG_ROLL_RATE]   <= 16'd64171;
			gain_q[REG_PITCH_RATE]  <= 16'd64171;
			gain_q[REG_YAW_RATE]    <= 16'd45837;
			timeout_q     <= 16'd500;
			want_q        <= '{default: '0};
			want_thrust_q <= '0;
			age_q         <= '0;
			stale_q       <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_ROLL_ANGLE, REG_PITCH_ANGLE, REG_YAW_ANGLE,
					REG_ROLL_RATE, REG_PITCH_RATE, REG_YAW_RATE: begin
						gain_q[wr_index] <= wr_data;
					end
					REG_TIMEOUT: timeout_q <= wr_data;
					default: begin
					end
				endcase
			end
			if (accept && opcode == OP_SETPOINT) begin
				want_q        <= in_vec;
				want_thrust_q <= thrust_cmd;
				age_q         <= '0;
			end else if (accept) begin
				age_q   <= age_n;
				stale_q <= stale_n;
				if (stale_n) begin
					want_q        <= '{default: '0};
					want_thrust_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_TICK) begin
			meas_q <= in_vec;
			mv_q   <= (battery_mv < MIN_BATTERY) ? MIN_BATTERY : battery_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_ACC_INIT) begin
				idx_q <= '0;
			end else if (state_q == S_TERMS) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign dthr    = (want_thrust_q > THRUST_OFFSET) ? want_thrust_q - THRUST_OFFSET : '0;
	assign err     = (DATA_WIDTH+1)'(meas_q[idx_q]) - (DATA_WIDTH+1)'(want_q[idx_q]);
	assign nominal = {1'b0, ures[19:0]} + NOMINAL_BASE;
	assign init_val = ACC_W'({nominal, 16'h0000});
	assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_n    = state_q;
		uctrl      = '{start: 1'b0, mode: MODE_SQRT};
		unum       = {dthr, 16'h0000};
		mcmd       = '{mul_en: 1'b0, acc_term: 1'b0, acc_init: 1'b0,
			kind: KIND_ROLL, rate: 1'b0};
		mul_a      = NOMINAL_SCALE;
		mul_b      = MB'($signed({1'b0, ures[15:0]}));
		case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_TICK) begin
					state_n = S_SQ_GO;
				end
			end
			S_SQ_GO: begin
				uctrl.start = 1'b1;
				state_n     = S_SQ_WAIT;
			end
			S_SQ_WAIT: begin
				if (udone) begin
					state_n = S_NOM_MUL;
				end
			end
			S_NOM_MUL: begin
				mcmd.mul_en = 1'b1;
				state_n     = S_DIV_GO;
			end
			S_DIV_GO: begin
				// Dividing by 4096*mV equals dropping 12 bits, then dividing by mV.
				uctrl = '{start: 1'b1, mode: MODE_DIV};
				unum  = {2'b00, prod[41:12]};
				state_n = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (udone) begin
					state_n = S_ACC_INIT;
				end
			end
			S_ACC_INIT: begin
				mcmd.acc_init = 1'b1;
				state_n       = S_TERMS;
			end
			S_TERMS: begin
				mcmd.mul_en   = 1'b1;
				mcmd.acc_term = 1'b1;
				mcmd.rate     = (idx_q >= 3'd3);
				case (idx_q)
					3'd0, 3'd3: mcmd.kind = KIND_ROLL;
					3'd1, 3'd4: mcmd.kind = KIND_PITCH;
					default:    mcmd.kind = KIND_YAW;
				endcase
				mul_a = {10'd0, gain_q[idx_q]};
				mul_b = MB'(err);
				if (idx_q == 3'd5) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_n = S_OUT;
			end
			S_OUT: begin
				if (load_out) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	qapm_shsub u_shsub (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (uctrl),
		.num    (unum),
		.den    (mv_q),
		.done   (udone),
		.result (ures)
	);

	qapm_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mcmd),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.init_val (init_val),
		.prod     (prod),
		.acc      (acc)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (acc[i][ACC_W-1]) begin
				motor[i] = '0;
			end else if (|acc[i][ACC_W-2:32]) begin
				motor[i] = MOTOR_MAX;
			end else begin
				motor[i] = acc[i][31:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			motor_q     <= motor;
			out_stale_q <= stale_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign motor_front    = motor_q[0];
	assign motor_right    = motor_q[1];
	assign motor_back     = motor_q[2];
	assign motor_left     = motor_q[3];
	assign setpoint_stale = out_stale_q;

	a_setpoint_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_SETPOINT |=> age_q == '0)
		else $error("setpoint transfer did not clear the age");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result appeared outside the output step");

	a_stale_zeroes_thrust: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> (!stale_q || want_thrust_q == '0))
		else $error("stale tick with nonzero thrust setpoint");

	a_unit_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		uctrl.start |-> (state_q == S_SQ_GO || state_q == S_DIV_GO))
		else $error("shared unit started outside a start step");

endmodule

/* rtl/qapm_shsub.sv */
// ----------------------------------------------------------------------------
// qapm_shsub
// Shared shift-compare-subtract unit: integer square root, two bits per
// cycle, or restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module qapm_shsub import qapm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  unit_ctrl_t  ctrl,
	input  logic [31:0] num,
	input  logic [12:0] den,
	output logic        done,
	output logic [31:0] result
);

	logic        busy_q, done_q;
	unit_mode_t  mode_q;
	logic [4:0]  cnt_q;
	logic [31:0] opnd_q, quo_q;
	logic [18:0] rem_q;
	logic [12:0] den_q;
	logic [18:0] cand, trial, diff;
	logic        ge;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			cand  = {rem_q[16:0], opnd_q[31:30]};
			trial = {1'b0, quo_q[15:0], 2'b01};
		end else begin
			cand  = {rem_q[17:0], opnd_q[31]};
			trial = {6'd0, den_q};
		end
		ge   = (cand >= trial);
		diff = cand - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctrl.mode == MODE_SQRT) ? 5'd15 : 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.mode;
			opnd_q <= num;
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff : cand;
			quo_q  <= {quo_q[30:0], ge};
			opnd_q <= (mode_q == MODE_SQRT) ? {opnd_q[29:0], 2'b00} : {opnd_q[30:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = quo_q;

endmodule

/* rtl/qapm_mac.sv */
// ----------------------------------------------------------------------------
// qapm_mac
// Shared multiplier with a product register and four motor accumulators.
// ----------------------------------------------------------------------------
module qapm_mac import qapm_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int MB = (DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17,
	localparam int PW = 27 + MB,
	localparam int ACC_W = PW + 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_cmd_t                cmd,
	input  logic [25:0]             mul_a,
	input  logic signed [MB-1:0]    mul_b,
	input  logic signed [ACC_W-1:0] init_val,
	output logic signed [PW-1:0]    prod,
	output logic signed [ACC_W-1:0] acc [4]
);

	logic signed [PW-1:0]    prod_s1;
	logic                    vld_s1, rate_s1;
	term_kind_t              kind_s1;
	logic signed [ACC_W-1:0] term, acc_q [4];

	always_comb begin
		term = ACC_W'(prod_s1);
		if (rate_s1) begin
			term = term <<< 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en && cmd.acc_term;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PW'($signed({1'b0, mul_a}) * mul_b);
			kind_s1 <= cmd.kind;
			rate_s1 <= cmd.rate;
		end
		if (cmd.acc_init) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= init_val;
			end
		end else if (vld_s1) begin
			// Plus frame: front and back take pitch, right and left take roll.
			case (kind_s1)
				KIND_ROLL: begin
					acc_q[1] <= acc_q[1] + term;
					acc_q[3] <= acc_q[3] - term;
				end
				KIND_PITCH: begin
					acc_q[0] <= acc_q[0] + term;
					acc_q[2] <= acc_q[2] - term;
				end
				KIND_YAW: begin
					acc_q[0] <= acc_q[0] + term;
					acc_q[1] <= acc_q[1] - term;
					acc_q[2] <= acc_q[2] + term;
					acc_q[3] <= acc_q[3] - term;
				end
				default: begin
				end
			endcase
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule
